// ----- src/arcs_pkg.sv -----
// Shared types and constants for the auto-ranging channel scaler.
// Used by arcs_front, arcs_back, the top level and the testbench; depends on nothing.
package arcs_pkg;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_DAMPEN = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [15:0] LOW_RESET  = 16'hFFFF;
  localparam logic [15:0] HIGH_RESET = 16'h0000;
  localparam logic [15:0] SPAN_RESET = 16'd500;
  localparam logic [6:0]  AMOUNT_MAX = 7'd100;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  channel;
    logic [15:0] sample;
    logic [6:0]  amount;
  } item_t;

endpackage

// ----- src/arcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module arcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/arcs_div.sv -----
// Radix-2 restoring divider for the scaling step, one quotient bit per cycle.
// The quotient is known to fit in 8 bits; no package dependencies.
module arcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [7:0]  quot
);

  logic [15:0] rem;
  logic [7:0]  bits;
  logic [3:0]  cnt;
  logic        active;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem, bits[7]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign quot  = bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // The upper 16 bits of the dividend are already below the divisor.
        rem    <= num[23:8];
        bits   <= num[7:0];
        cnt    <= 4'd8;
        active <= 1'b1;
      end else if (active) begin
        rem  <= ge ? diff[15:0] : trial[15:0];
        bits <= {bits[6:0], ge};
        cnt  <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/arcs_front.sv -----
// Front end: accepts requests, drops those with no effect, clamps the
// dampen amount and queues the rest. Depends on arcs_pkg.
module arcs_front #(
  parameter int CHANNELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [7:0]         channel,
  input  logic [15:0]        sample,
  input  logic [15:0]        damp_amount,
  output logic               head_valid,
  output arcs_pkg::item_t    head,
  input  logic               head_pop
);

  arcs_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            keep;
  logic            push;
  arcs_pkg::item_t entry;

  assign in_ready   = en && (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_comb begin
    case (func)
      arcs_pkg::FUNC_SAMPLE: keep = ({24'd0, channel} < 32'(CHANNELS));
      arcs_pkg::FUNC_DAMPEN: keep = 1'b1;
      arcs_pkg::FUNC_CLEAR:  keep = 1'b1;
      default:               keep = 1'b0;
    endcase
    entry.op      = func;
    entry.channel = channel;
    entry.sample  = sample;
    entry.amount  = (damp_amount > {9'd0, arcs_pkg::AMOUNT_MAX}) ?
                    arcs_pkg::AMOUNT_MAX : damp_amount[6:0];
  end

  assign push = in_valid && in_ready && keep;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (head_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, head_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/arcs_back.sv -----
// Back end: owns the mark memory, runs the clear and dampen sweeps and the
// scaling of samples, and holds the output register. Depends on arcs_pkg,
// arcs_ram and arcs_div.
module arcs_back #(
  parameter int CHANNELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  arcs_pkg::item_t    head,
  output logic               head_pop,
  input  logic [15:0]        min_span,
  output logic               init_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_channel,
  output logic [7:0]         scaled
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_DAMP   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_PREP   = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_RESULT = 3'd7;

  logic [2:0]       state;
  arcs_pkg::item_t  cur;
  logic [AW-1:0]    idx;
  logic             idx_last;
  logic             issuing;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;

  // Sample path.
  logic [15:0]      rd_lo;
  logic [15:0]      rd_hi;
  logic [15:0]      new_lo;
  logic [15:0]      new_hi;
  logic [15:0]      new_span;
  logic [15:0]      diff;
  logic [15:0]      den;
  logic [23:0]      num;
  logic             div_start;
  logic             div_done;
  logic [7:0]       div_quot;
  logic             load_out;

  // Dampen sweep pipeline.
  logic             s1_v;
  logic [AW-1:0]    s1_addr;
  logic             s2_v;
  logic [AW-1:0]    s2_addr;
  logic [15:0]      s2_lo;
  logic [15:0]      s2_hi;
  logic             s2_lt;
  logic [15:0]      s2_span;
  logic [22:0]      s2_prod;
  logic             s3_v;
  logic [AW-1:0]    s3_addr;
  logic [15:0]      s3_lo;
  logic [15:0]      s3_hi;
  logic             s3_lt;
  logic [15:0]      s3_span;
  logic [15:0]      s3_quot;
  logic [15:0]      amt16;
  logic [15:0]      cut;
  logic [15:0]      d_span;
  logic [46:0]      recip_prod;

  arcs_ram #(
    .WIDTH (32),
    .DEPTH (CHANNELS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  arcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign idx_last  = (idx == AW'(CHANNELS - 1));
  assign init_done = (state != ST_INIT);

  assign rd_lo    = ram_rdata[15:0];
  assign rd_hi    = ram_rdata[31:16];
  assign new_lo   = (cur.sample < rd_lo) ? cur.sample : rd_lo;
  assign new_hi   = (cur.sample > rd_hi) ? cur.sample : rd_hi;
  assign new_span = new_hi - new_lo;
  assign num      = {diff, 8'd0} - {8'd0, diff};
  assign load_out = (state == ST_RESULT) && (!out_valid || out_ready);

  assign d_span     = rd_hi - rd_lo;
  assign recip_prod = {24'd0, s2_prod} * {23'd0, arcs_pkg::RECIP_100};
  assign amt16      = {9'd0, cur.amount};

  always_comb begin
    if (s3_quot < amt16) begin
      cut = (amt16 > s3_span) ? s3_span : amt16;
    end else begin
      cut = s3_quot;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {arcs_pkg::HIGH_RESET, arcs_pkg::LOW_RESET};
    ram_raddr = AW'(head.channel);
    head_pop  = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        head_pop = head_valid;
      end
      ST_DAMP: begin
        ram_raddr = idx;
        if (s3_v && s3_lt) begin
          ram_we    = 1'b1;
          ram_waddr = s3_addr;
          ram_wdata = {s3_hi - cut, s3_lo + cut};
        end
      end
      ST_READ: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cur.channel);
        ram_wdata = {new_hi, new_lo};
      end
      ST_PREP: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Dampen pipeline registers carry payload only; their valids are reset below.
  always_ff @(posedge clk) begin
    s1_addr    <= idx;
    s2_addr    <= s1_addr;
    s2_lo      <= rd_lo;
    s2_hi      <= rd_hi;
    s2_lt      <= rd_lo < rd_hi;
    s2_span    <= d_span;
    s2_prod    <= {7'd0, d_span} * {16'd0, cur.amount};
    s3_addr    <= s2_addr;
    s3_lo      <= s2_lo;
    s3_hi      <= s2_hi;
    s3_lt      <= s2_lt;
    s3_span    <= s2_span;
    s3_quot    <= recip_prod[arcs_pkg::RECIP_SHIFT +: 16];
    if (state == ST_IDLE && head_valid) begin
      cur <= head;
    end
    if (state == ST_READ) begin
      diff <= cur.sample - new_lo;
      den  <= (new_span < min_span) ? min_span : new_span;
    end
    if (load_out) begin
      out_channel <= cur.channel;
      scaled      <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      idx       <= '0;
      issuing   <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_DAMP) && issuing;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT, ST_CLEAR: begin
          if (idx_last) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (head_valid) begin
            idx <= '0;
            case (head.op)
              arcs_pkg::FUNC_SAMPLE: state <= ST_READ;
              arcs_pkg::FUNC_DAMPEN: begin
                state   <= ST_DAMP;
                issuing <= 1'b1;
              end
              arcs_pkg::FUNC_CLEAR:  state <= ST_CLEAR;
              default:               state <= ST_IDLE;
            endcase
          end
        end
        ST_DAMP: begin
          if (issuing) begin
            if (idx_last) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + AW'(1);
            end
          end else if (!s1_v && !s2_v && !s3_v) begin
            state <= ST_IDLE;
          end
        end
        ST_READ: state <= ST_PREP;
        ST_PREP: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/auto_ranging_channel_scaler.sv -----
// Top level of the auto-ranging channel scaler: configuration register,
// front end and back end. Depends on arcs_pkg, arcs_front and arcs_back.
//
//   Channel   Signals                                                  Direction
//   -------   ------------------------------------------------------   ---------
//   config    cfg_we, cfg_wdata (minimum_span)                         in
//   request   in_valid/in_ready, func, channel, sample, damp_amount    in
//   result    out_valid/out_ready, out_channel, scaled                 out
//
// A sample request in the back end reads and updates its marks, then runs the eight
// iterations of the radix-2 divider. Dampen requests sweep the whole mark memory,
// and clear requests reset every mark. After rst a clearing pass fills the mark
// memory; in_ready stays low during it. A two-entry request queue lets the
// front end keep taking requests while the back end is busy, and the output
// register holds a result while later requests without results proceed.
module auto_ranging_channel_scaler #(
  parameter int CHANNELS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  channel,
  input  logic [15:0] sample,
  input  logic [15:0] damp_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_channel,
  output logic [7:0]  scaled
);

  logic [15:0]     min_span;
  logic            init_done;
  logic            head_valid;
  logic            head_pop;
  arcs_pkg::item_t head;

  // A written zero is kept as one so the divisor never vanishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_span <= arcs_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      min_span <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
    end
  end

  arcs_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (init_done),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .channel     (channel),
    .sample      (sample),
    .damp_amount (damp_amount),
    .head_valid  (head_valid),
    .head        (head),
    .head_pop    (head_pop)
  );

  arcs_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .head_pop    (head_pop),
    .min_span    (min_span),
    .init_done   (init_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .scaled      (scaled)
  );

endmodule

// ----- tb/auto_ranging_channel_scaler_tb.sv -----
// Self-checking testbench for auto_ranging_channel_scaler: a table of directed
// requests followed by shaped random traffic, checked against a local model.
// Depends on arcs_pkg and the auto_ranging_channel_scaler RTL.
module auto_ranging_channel_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH           = 256;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_DIRECTED     = 24;
  localparam int GROUP2_START   = 17;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int N_PHASES       = 4;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [15:0] smp;
    logic [15:0] amt;
    logic        fixed;
    logic [7:0]  fixed_val;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] channel;
    logic [7:0] scaled;
  } scaled_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  channel;
  logic [15:0] sample;
  logic [15:0] damp_amount;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_channel;
  logic [7:0]  scaled;

  // Local copy of the block's marks and span floor.
  logic [15:0] low_mark [N_CH];
  logic [15:0] high_mark [N_CH];
  logic [15:0] span_floor;

  scaled_result_t expected_scaled [$];
  stim_row_t      directed_rows [N_DIRECTED];

  int tx_idle_pct;
  int rx_idle_pct;
  int holdoff_req;
  int holdoff_seen;
  int hold_left;
  int stall_cycles;
  int fail_count;
  int results_seen;
  int requests_sent;
  int span_writes;

  auto_ranging_channel_scaler #(
    .CHANNELS(N_CH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .channel    (channel),
    .sample     (sample),
    .damp_amount(damp_amount),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_channel(out_channel),
    .scaled     (scaled)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic clear_marks();
    for (int k = 0; k < N_CH; k++) begin
      low_mark[k]  = arcs_pkg::LOW_RESET;
      high_mark[k] = arcs_pkg::HIGH_RESET;
    end
  endtask

  // Updates the local marks for one request and works out its scaled value.
  task automatic track_and_scale(input logic [1:0] op, input logic [7:0] ch,
                                 input logic [15:0] smp, input logic [15:0] amt,
                                 output bit produced, output logic [7:0] val);
    int unsigned lo;
    int unsigned hi;
    int unsigned range_w;
    int unsigned a;
    int unsigned cut;
    produced = 1'b0;
    val = '0;
    case (op)
      arcs_pkg::FUNC_SAMPLE: begin
        if (ch < N_CH) begin
          if (smp < low_mark[ch]) low_mark[ch] = smp;
          if (smp > high_mark[ch]) high_mark[ch] = smp;
          lo = low_mark[ch];
          hi = high_mark[ch];
          range_w = hi - lo;
          if (range_w < span_floor) range_w = span_floor;
          if (range_w == 0) range_w = 1;
          val = 8'((32'(smp) - lo) * 255 / range_w);
          produced = 1'b1;
        end
      end
      arcs_pkg::FUNC_DAMPEN: begin
        a = (amt > arcs_pkg::AMOUNT_MAX) ? arcs_pkg::AMOUNT_MAX : amt;
        for (int k = 0; k < N_CH; k++) begin
          lo = low_mark[k];
          hi = high_mark[k];
          if (lo < hi) begin
            range_w = hi - lo;
            cut = range_w * a / 100;
            if (cut < a) begin
              cut = a;
              if (cut > range_w) cut = range_w;
            end
            low_mark[k]  = 16'(lo + cut);
            high_mark[k] = 16'(hi - cut);
          end
        end
      end
      arcs_pkg::FUNC_CLEAR: clear_marks();
      default: ;
    endcase
  endtask

  // Offers one request and, once it is taken, records what it should produce.
  task automatic send_request(input stim_row_t row);
    bit          produced;
    logic [7:0]  val;
    @(negedge clk);
    in_valid    <= 1'b1;
    func        <= row.op;
    channel     <= row.ch;
    sample      <= row.smp;
    damp_amount <= row.amt;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    track_and_scale(row.op, row.ch, row.smp, row.amt, produced, val);
    if (row.fixed) expected_scaled.push_back(scaled_result_t'{row.ch, row.fixed_val});
    else if (produced) expected_scaled.push_back(scaled_result_t'{row.ch, val});
  endtask

  task automatic pace_sender();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scaled.size() != 0) @(posedge clk);
  endtask

  // Requests without results may still be sweeping the marks, so let them finish.
  task automatic drain_block();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_span(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    span_floor = (value == 0) ? 16'd1 : value;
    span_writes++;
  endtask

  task automatic make_random_row(output stim_row_t row);
    int r;
    int v;
    r = $urandom_range(0, 99);
    row = '0;
    row.ch  = 8'($urandom_range(0, 255));
    row.smp = 16'($urandom_range(0, 65535));
    row.amt = 16'($urandom_range(0, 65535));
    if (r < 80) begin
      row.op = arcs_pkg::FUNC_SAMPLE;
      // Most samples land on a few busy channels near a per-channel level.
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: row.ch = 8'd3;
          1: row.ch = 8'd77;
          2: row.ch = 8'd200;
          default: row.ch = 8'd255;
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        v = int'(row.ch) * 256 + int'($urandom_range(0, 3000)) - 1500;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        row.smp = 16'(v);
      end
    end else if (r < 88) begin
      row.op = arcs_pkg::FUNC_DAMPEN;
      if ($urandom_range(0, 9) < 7) row.amt = 16'($urandom_range(0, 120));
    end else if (r < 92) begin
      row.op = arcs_pkg::FUNC_CLEAR;
    end else begin
      row.op = FUNC_UNUSED;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request from the main flow.
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen = holdoff_req;
      hold_left = HOLDOFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without progress.", stall_cycles);
      $display("FAILURE");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_scaled.size() == 0) begin
        $error("unexpected result: out_channel %0d scaled %0d", out_channel, scaled);
        fail_count++;
      end else begin
        scaled_result_t exp_r;
        exp_r = expected_scaled.pop_front();
        if (out_channel !== exp_r.channel) begin
          $error("out_channel: expected %0d, actual %0d", exp_r.channel, out_channel);
          fail_count++;
        end
        if (scaled !== exp_r.scaled) begin
          $error("scaled: expected %0d, actual %0d", exp_r.scaled, scaled);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    int          counted;
    logic [15:0] phase_span;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    func         = arcs_pkg::FUNC_SAMPLE;
    channel      = '0;
    sample       = '0;
    damp_amount  = '0;
    tx_idle_pct  = 31;
    rx_idle_pct  = 77;
    holdoff_req  = 0;
    holdoff_seen = 0;
    hold_left    = 0;
    stall_cycles = 0;
    fail_count   = 0;
    results_seen = 0;
    requests_sent = 0;
    span_writes  = 0;
    clear_marks();
    span_floor = arcs_pkg::SPAN_RESET;

    // Fixed values hold for first samples after reset or clear and for the
    // full-scale extremes; the rest go through the local model.
    directed_rows = '{
      '{arcs_pkg::FUNC_SAMPLE, 8'd0,   16'd0,     16'd0,     1'b1, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'hFFFF,  16'd0,     1'b1, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'd0,     16'd0,     1'b1, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'hFFFF,  16'd0,     1'b1, 8'd255},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'd32768, 16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd0,   16'd300,   16'd0,     1'b0, 8'd0},
      '{FUNC_UNUSED,           8'd7,   16'd1234,  16'd99,    1'b0, 8'd0},
      '{arcs_pkg::FUNC_DAMPEN, 8'd0,   16'd0,     16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'hFFFF,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_DAMPEN, 8'd0,   16'd0,     16'hFFFF,  1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd255, 16'd40000, 16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd1,   16'd1000,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd1,   16'd1050,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_DAMPEN, 8'd0,   16'd0,     16'd30,    1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd1,   16'd1025,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_CLEAR,  8'd0,   16'd0,     16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd1,   16'd5,     16'd0,     1'b1, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd2,   16'd100,   16'd0,     1'b1, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd2,   16'd101,   16'd0,     1'b1, 8'd255},
      '{arcs_pkg::FUNC_SAMPLE, 8'hAA,  16'hAAAA,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'h55,  16'h5555,  16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_DAMPEN, 8'd0,   16'd0,     16'd100,   1'b0, 8'd0},
      '{arcs_pkg::FUNC_SAMPLE, 8'd2,   16'd100,   16'd0,     1'b0, 8'd0},
      '{arcs_pkg::FUNC_DAMPEN, 8'd0,   16'd0,     16'h5555,  1'b0, 8'd0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      // The second group runs with a zero span write, which must act as one.
      if (i == GROUP2_START) begin
        drain_block();
        write_span(16'd0);
      end
      pace_sender();
      send_request(directed_rows[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin phase_span = 16'hFFFF; tx_idle_pct = 31; rx_idle_pct = 77; end
        1: begin
          phase_span = 16'($urandom_range(2, 65534));
          tx_idle_pct = 77;
          rx_idle_pct = 31;
        end
        2: begin phase_span = 16'd1; tx_idle_pct = 0; rx_idle_pct = 0; end
        default: begin
          phase_span = arcs_pkg::SPAN_RESET;
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      drain_block();
      write_span(phase_span);
      if (p == 2) holdoff_req++;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (p == 1 && counted == ITEMS_PER_PHASE / 2) wait_results();
        make_random_row(row);
        pace_sender();
        send_request(row);
        if (row.op != FUNC_UNUSED) counted++;
      end
    end

    drain_block();
    $display("Sent %0d requests (%0d from the table) under %0d span settings;",
             requests_sent, N_DIRECTED, span_writes + 1);
    $display("checked %0d scaled results with %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
